// ----- rtl/core/i2cmrt_pkg.sv -----
// Shared types and constants for the I2C register-transfer sequencer.
// Depends on nothing; used by the channel interfaces and the top-level sequencer.
package i2cmrt_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SLAVE_ADDRESS    = 2'd0,
    CFG_REGISTER_ADDRESS = 2'd1,
    CFG_TRANSFER_LENGTH  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    CMD_LOAD        = 2'd0,
    CMD_START_READ  = 2'd1,
    CMD_START_WRITE = 2'd2,
    CMD_EVENT       = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_RESTART = 3'd2,
    ACT_SEND    = 3'd3,
    ACT_RX_ACK  = 3'd4,
    ACT_RX_NACK = 3'd5,
    ACT_STOP    = 3'd6
  } action_t;

  // Bus engine status codes
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_REPSTART  = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_DATW_ACK  = 8'h28;
  localparam logic [7:0] ST_DATW_NACK = 8'h30;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_DATR_ACK  = 8'h50;
  localparam logic [7:0] ST_DATR_NACK = 8'h58;

  localparam logic RW_READ = 1'b1;

  typedef struct packed {
    action_t     action;
    logic [7:0]  transmit_byte;
    logic        busy_res;
    logic        capture_valid;
    logic [3:0]  capture_index;
    logic [7:0]  capture_byte;
  } result_t;

endpackage

// ----- rtl/core/i2cmrt_req_if.sv -----
// Request channel: valid/ready handshake with the command payload.
// Depends on i2cmrt_pkg for the command type.
interface i2cmrt_req_if;
  logic                valid;
  logic                ready;
  i2cmrt_pkg::cmd_t    cmd;
  logic [7:0]          bus_status;
  logic [7:0]          received_byte;
  logic [3:0]          load_index;
  logic [7:0]          load_byte;

  modport source (output valid, cmd, bus_status, received_byte, load_index, load_byte,
                  input ready);
  modport sink   (input valid, cmd, bus_status, received_byte, load_index, load_byte,
                  output ready);
endinterface

// ----- rtl/core/i2cmrt_res_if.sv -----
// Result channel: valid/ready handshake with the bus action and capture fields.
// Depends on i2cmrt_pkg for the action type.
interface i2cmrt_res_if;
  logic                  valid;
  logic                  ready;
  i2cmrt_pkg::action_t   action;
  logic [7:0]            transmit_byte;
  logic                  busy_res;
  logic                  capture_valid;
  logic [3:0]            capture_index;
  logic [7:0]            capture_byte;

  modport source (output valid, action, transmit_byte, busy_res, capture_valid,
                  capture_index, capture_byte, input ready);
  modport sink   (input valid, action, transmit_byte, busy_res, capture_valid,
                  capture_index, capture_byte, output ready);
endinterface

// ----- rtl/core/i2c_master_register_transfer.sv -----
// I2C master register-transfer sequencer: top level.
// Depends on i2cmrt_pkg, i2cmrt_req_if, i2cmrt_res_if and i2cmrt_ram.
//
// Usage
//   req channel carries one request per handshake: load a transmit byte,
//   start a read, start a write, or report a bus engine status event.
//   res channel returns exactly one result per request: the next bus
//   action, the byte to transmit, the busy flag after the request and,
//   for received data, the captured byte and its position.
//   The config port (cfg_we, cfg_index, cfg_data) sets slave address,
//   register address and transfer length; write it only while idle.
// Timing
//   A request is decoded in the cycle it is accepted; its result is
//   registered in the result register, or in the skid entry while res
//   stalls. One request per cycle is sustained while res does not stall,
//   set by the single decode step before the result register.
// Stall
//   A result register plus one skid entry: req.ready stays high while the
//   skid entry is empty, so one more request is taken while res stalls.
// Reset
//   rst (synchronous) holds req.ready low and clears busy, direction, byte
//   counter, config registers (transfer length to 1) and both result slots.
//   The transmit buffer is not cleared; unloaded slots send unspecified bytes.
module i2c_master_register_transfer #(
  parameter int BUFFER_DEPTH = i2cmrt_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  i2cmrt_req_if.sink                           req,
  i2cmrt_res_if.source                         res,
  input  logic                                 cfg_we,
  input  logic [i2cmrt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [i2cmrt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [8:0] DEPTH_LIM = 9'(BUFFER_DEPTH);

  // Config registers
  logic [6:0] slave_address;
  logic [7:0] register_address;
  logic [4:0] transfer_length;

  // Sequencer state
  logic [4:0] byte_count;
  logic [4:0] byte_count_next;
  logic       read_mode;
  logic       read_mode_next;
  logic       busy;
  logic       busy_next;

  // Result register and skid entry
  i2cmrt_pkg::result_t out_q;
  i2cmrt_pkg::result_t skid_q;
  i2cmrt_pkg::result_t result;
  logic                out_valid;
  logic                skid_full;

  // Transmit buffer read path with write bypass
  logic [7:0]    ram_rdata;
  logic [AW-1:0] ram_raddr;
  logic [AW-1:0] ram_waddr;
  logic          ram_we;
  logic          bypass_hit;
  logic [7:0]    bypass_byte;
  logic [7:0]    store_byte;
  logic [8:0]    cnt_ext;
  logic [8:0]    cnt_next_ext;
  logic [8:0]    lidx_ext;

  logic acc;
  logic take;

  assign acc  = req.valid && req.ready;
  assign take = res.valid && res.ready;

  assign req.ready = !skid_full && !rst;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address    <= '0;
      register_address <= '0;
      transfer_length  <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cmrt_pkg::CFG_SLAVE_ADDRESS:    slave_address    <= cfg_data[6:0];
        i2cmrt_pkg::CFG_REGISTER_ADDRESS: register_address <= cfg_data[7:0];
        i2cmrt_pkg::CFG_TRANSFER_LENGTH:  transfer_length  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Transmit buffer. The read address always tracks the next byte count, so
  // the registered read data holds the slot for the current count. A load
  // to that same slot in the same cycle is caught by the bypass register.
  // ---------------------------------------------------------------------------
  assign cnt_ext      = 9'(byte_count);
  assign cnt_next_ext = 9'(byte_count_next);
  assign lidx_ext     = 9'(req.load_index);
  assign ram_raddr    = cnt_next_ext[AW-1:0];
  assign ram_waddr    = lidx_ext[AW-1:0];
  assign ram_we       = acc && (req.cmd == i2cmrt_pkg::CMD_LOAD) && (lidx_ext < DEPTH_LIM);

  i2cmrt_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.load_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    bypass_hit  <= ram_we && (ram_waddr == ram_raddr);
    bypass_byte <= req.load_byte;
  end

  assign store_byte = bypass_hit ? bypass_byte : ram_rdata;

  // ---------------------------------------------------------------------------
  // Request decode: one request (load, start or status event) in, next bus action out
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [4:0] cnt_work;
    logic [5:0] cnt_plus;
    logic       rx_ack;

    result          = '0;
    result.action   = i2cmrt_pkg::ACT_NONE;
    cnt_work        = byte_count;
    read_mode_next  = read_mode;
    busy_next       = busy;
    cnt_plus        = '0;
    rx_ack          = 1'b0;

    case (req.cmd)
      i2cmrt_pkg::CMD_LOAD: ;
      i2cmrt_pkg::CMD_START_READ,
      i2cmrt_pkg::CMD_START_WRITE: begin
        busy_next      = 1'b1;
        read_mode_next = (req.cmd == i2cmrt_pkg::CMD_START_READ);
        result.action  = i2cmrt_pkg::ACT_START;
      end
      default: begin
        case (req.bus_status)
          i2cmrt_pkg::ST_START: begin
            cnt_work             = '0;
            result.action        = i2cmrt_pkg::ACT_SEND;
            result.transmit_byte = {slave_address, 1'b0};
          end
          i2cmrt_pkg::ST_SLAW_ACK: begin
            result.action        = i2cmrt_pkg::ACT_SEND;
            result.transmit_byte = register_address;
          end
          i2cmrt_pkg::ST_DATW_ACK: begin
            if (read_mode) begin
              result.action = i2cmrt_pkg::ACT_RESTART;
            end else if (byte_count < transfer_length) begin
              result.action        = i2cmrt_pkg::ACT_SEND;
              result.transmit_byte = (cnt_ext < DEPTH_LIM) ? store_byte : 8'h00;
              cnt_work             = byte_count + 5'd1;
            end else begin
              result.action = i2cmrt_pkg::ACT_STOP;
              busy_next     = 1'b0;
            end
          end
          i2cmrt_pkg::ST_REPSTART: begin
            result.action        = i2cmrt_pkg::ACT_SEND;
            result.transmit_byte = {slave_address, i2cmrt_pkg::RW_READ};
          end
          i2cmrt_pkg::ST_DATR_ACK: begin
            // Capture first; the ACK/NACK choice sees the advanced count
            result.capture_valid = 1'b1;
            result.capture_index = byte_count[3:0];
            result.capture_byte  = req.received_byte;
            cnt_work             = byte_count + 5'd1;
            cnt_plus             = 6'(cnt_work) + 6'd1;
            rx_ack               = (transfer_length != 5'd0) &&
                                   (cnt_plus < 6'(transfer_length));
            result.action        = rx_ack ? i2cmrt_pkg::ACT_RX_ACK
                                          : i2cmrt_pkg::ACT_RX_NACK;
          end
          i2cmrt_pkg::ST_SLAR_ACK: begin
            cnt_plus      = 6'(byte_count) + 6'd1;
            rx_ack        = (transfer_length != 5'd0) &&
                            (cnt_plus < 6'(transfer_length));
            result.action = rx_ack ? i2cmrt_pkg::ACT_RX_ACK
                                   : i2cmrt_pkg::ACT_RX_NACK;
          end
          i2cmrt_pkg::ST_DATR_NACK: begin
            result.capture_valid = 1'b1;
            result.capture_index = byte_count[3:0];
            result.capture_byte  = req.received_byte;
            cnt_work             = byte_count + 5'd1;
            result.action        = i2cmrt_pkg::ACT_STOP;
            busy_next            = 1'b0;
          end
          default: begin
            // Bus error, address or data NACK, lost arbitration, unknown code
            result.action = i2cmrt_pkg::ACT_STOP;
            busy_next     = 1'b0;
          end
        endcase
      end
    endcase

    result.busy_res = busy_next;
    byte_count_next = acc ? cnt_work : byte_count;
  end

  // ---------------------------------------------------------------------------
  // Sequencer state: advance only on an accepted request
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      read_mode  <= 1'b0;
      busy       <= 1'b0;
    end else begin
      byte_count <= byte_count_next;
      if (acc) begin
        read_mode <= read_mode_next;
        busy      <= busy_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register and skid entry
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || take) begin
      out_valid <= skid_full || acc;
      if (skid_full) begin
        // Drain skid into the result register; refill skid on a new request
        skid_full <= acc;
      end
    end else if (acc) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_full) begin
        out_q <= skid_q;
        if (acc) begin
          skid_q <= result;
        end
      end else if (acc) begin
        out_q <= result;
      end
    end else if (acc) begin
      skid_q <= result;
    end
  end

  assign res.valid         = out_valid;
  assign res.action        = out_q.action;
  assign res.transmit_byte = out_q.transmit_byte;
  assign res.busy_res      = out_q.busy_res;
  assign res.capture_valid = out_q.capture_valid;
  assign res.capture_index = out_q.capture_index;
  assign res.capture_byte  = out_q.capture_byte;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid entry full while result register empty");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    acc && (req.cmd == i2cmrt_pkg::CMD_START_READ ||
            req.cmd == i2cmrt_pkg::CMD_START_WRITE) |=> busy)
    else $error("start request did not mark the sequencer busy");

  a_capture_action: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.capture_valid |-> (res.action == i2cmrt_pkg::ACT_RX_ACK ||
                                        res.action == i2cmrt_pkg::ACT_RX_NACK ||
                                        res.action == i2cmrt_pkg::ACT_STOP))
    else $error("captured byte with an action other than receive or stop");

  a_stop_frees: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.action == i2cmrt_pkg::ACT_STOP |-> !res.busy_res)
    else $error("stop issued while result still reports busy");

  a_tx_only_on_send: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.action != i2cmrt_pkg::ACT_SEND |-> res.transmit_byte == 8'h00)
    else $error("transmit byte set on a non-transmit action");

endmodule

// ----- rtl/core/i2cmrt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2cmrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
